@@ rtl/core/bpr_matrix_factor_sgd_step_top_defines.svh @@
// ----------------------------------------------------------------------------
// BPR SGD step engine assertion macros
// Shared property shorthands for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef BPR_MATRIX_FACTOR_SGD_STEP_TOP_DEFINES_SVH
`define BPR_MATRIX_FACTOR_SGD_STEP_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bpr_pkg.sv @@
// ----------------------------------------------------------------------------
// BPR SGD step package
// Store sizes, codes, word types and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bpr_pkg;

    localparam int MAX_USERS   = 1024;
    localparam int MAX_ITEMS   = 4096;
    localparam int MAX_FACTORS = 64;

    localparam int USER_IW = $clog2(MAX_USERS);
    localparam int ITEM_IW = $clog2(MAX_ITEMS);
    localparam int FIDX_W  = $clog2(MAX_FACTORS);
    localparam int FCNT_W  = $clog2(MAX_FACTORS + 1);
    localparam int UADDR_W = USER_IW + FIDX_W;
    localparam int IADDR_W = ITEM_IW + FIDX_W;
    localparam int ACC_W   = 33 + FCNT_W;
    localparam int STEP_W  = 4;
    localparam int NUM_OPS = 9;

    localparam logic [1:0] MODE_LOAD_USER = 2'd0;
    localparam logic [1:0] MODE_LOAD_ITEM = 2'd1;
    localparam logic [1:0] MODE_TRAIN     = 2'd2;
    localparam logic [1:0] MODE_PREDICT   = 2'd3;

    localparam logic [2:0] CFG_LEARN_RATE  = 3'd0;
    localparam logic [2:0] CFG_LAMBDA_USER = 3'd1;
    localparam logic [2:0] CFG_LAMBDA_POS  = 3'd2;
    localparam logic [2:0] CFG_LAMBDA_NEG  = 3'd3;
    localparam logic [2:0] CFG_FACTORS     = 3'd4;
    localparam logic [2:0] CFG_USERS       = 3'd5;
    localparam logic [2:0] CFG_ITEMS       = 3'd6;
    localparam logic [2:0] CFG_GLOBAL_MEAN = 3'd7;

    localparam logic [15:0] RST_LEARN_RATE = 16'd6554;
    localparam logic [15:0] RST_LAMBDA     = 16'd655;
    localparam logic [6:0]  RST_FACTORS    = 7'd64;
    localparam logic [10:0] RST_USERS      = 11'd1024;
    localparam logic [12:0] RST_ITEMS      = 13'd4096;

    localparam logic [STEP_W-1:0] OP_D_DIFF  = 4'd0;
    localparam logic [STEP_W-1:0] OP_LU_W    = 4'd1;
    localparam logic [STEP_W-1:0] OP_D_W     = 4'd2;
    localparam logic [STEP_W-1:0] OP_LP_HI   = 4'd3;
    localparam logic [STEP_W-1:0] OP_D_NEGW  = 4'd4;
    localparam logic [STEP_W-1:0] OP_LN_HJ   = 4'd5;
    localparam logic [STEP_W-1:0] OP_LR_GU   = 4'd6;
    localparam logic [STEP_W-1:0] OP_LR_GI   = 4'd7;
    localparam logic [STEP_W-1:0] OP_LR_GJ   = 4'd8;
    localparam logic [STEP_W-1:0] OP_RETIRE  = 4'd9;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         user_index;
        logic [11:0]        pos_item_index;
        logic [11:0]        neg_item_index;
        logic [5:0]         factor_index;
        logic signed [31:0] factor_value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               status;
    } t_result;

    typedef struct packed {
        logic              capture;
        logic              load;
        logic              res_err;
        logic              rd;
        logic              dot;
        logic              xsat;
        logic              sig;
        logic              op_en;
        logic [STEP_W-1:0] op_step;
        logic              wr_i;
        logic              wr_j;
        logic [FIDX_W-1:0] f;
    } t_dp_ctl;

    typedef struct packed {
        logic [1:0]        mode;
        logic              load_err;
        logic              rng_err;
        logic [FCNT_W-1:0] nf;
        logic              dot_busy;
    } t_dp_sts;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Round half up, then arithmetic shift right.
    function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                   input int sh);
        logic signed [65:0] t;
        t = v + (66'sd1 <<< (sh - 1));
        return t >>> sh;
    endfunction

    function automatic logic [15:0] sig_tab(input logic [4:0] idx);
        logic [15:0] r;
        unique case (idx)
            5'd0:    r = 16'd32768;
            5'd1:    r = 16'd24743;
            5'd2:    r = 16'd17625;
            5'd3:    r = 16'd11955;
            5'd4:    r = 16'd7812;
            5'd5:    r = 16'd4971;
            5'd6:    r = 16'd3108;
            5'd7:    r = 16'd1921;
            5'd8:    r = 16'd1179;
            5'd9:    r = 16'd720;
            5'd10:   r = 16'd439;
            5'd11:   r = 16'd267;
            5'd12:   r = 16'd162;
            5'd13:   r = 16'd98;
            5'd14:   r = 16'd60;
            5'd15:   r = 16'd36;
            default: r = 16'd22;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bpr_dp.sv @@
// ----------------------------------------------------------------------------
// BPR SGD step datapath
// Factor stores, configuration registers, dot pipeline, sigmoid and update.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bpr_pkg::t_cmd     i_cmd,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire bpr_pkg::t_dp_ctl  i_ctl,
    output bpr_pkg::t_dp_sts       o_sts,
    output bpr_pkg::t_result       o_result
);

    logic [15:0]        r_lr, r_lu, r_lp, r_ln;
    logic [6:0]         r_factors;
    logic [10:0]        r_users;
    logic [12:0]        r_items;
    logic signed [31:0] r_gmean;

    bpr_pkg::t_cmd      r_cmd;
    bpr_pkg::t_result   r_res;

    logic [31:0] user_mem [0:(1 << bpr_pkg::UADDR_W) - 1];
    logic [31:0] item_mem [0:(1 << bpr_pkg::IADDR_W) - 1];

    logic signed [31:0] r_w, r_hi, r_hj, r_wq, r_diff, r_x, r_newi;
    logic signed [65:0] r_prod;
    logic signed [bpr_pkg::ACC_W-1:0] r_acc;
    logic               r_v1, r_v2, r_v3;
    logic [15:0]        r_d;
    logic signed [31:0] r_m [0:bpr_pkg::NUM_OPS-1];

    logic [bpr_pkg::UADDR_W-1:0] u_addr, u_wr_addr;
    logic [bpr_pkg::IADDR_W-1:0] i_addr, j_addr, it_wr_addr;
    logic        u_we, it_we, is_load, load_err, u_bad, i_bad, j_bad;
    logic [31:0] u_wr_data, it_wr_data;
    logic signed [31:0] gu, gi, gj, new_w, new_hi, new_j, j_base, x_sat;
    logic signed [32:0] mul_a, mul_b;

    logic [32:0] x_abs;
    logic [27:0] a_cl;
    logic [4:0]  s_idx;
    logic [22:0] s_frac;
    logic [15:0] t0, t1, drop;
    logic [37:0] interp;
    logic [16:0] d_pos, d_fin;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr      <= bpr_pkg::RST_LEARN_RATE;
            r_lu      <= bpr_pkg::RST_LAMBDA;
            r_lp      <= bpr_pkg::RST_LAMBDA;
            r_ln      <= bpr_pkg::RST_LAMBDA;
            r_factors <= bpr_pkg::RST_FACTORS;
            r_users   <= bpr_pkg::RST_USERS;
            r_items   <= bpr_pkg::RST_ITEMS;
            r_gmean   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpr_pkg::CFG_LEARN_RATE:  r_lr      <= i_cfg_data[15:0];
                bpr_pkg::CFG_LAMBDA_USER: r_lu      <= i_cfg_data[15:0];
                bpr_pkg::CFG_LAMBDA_POS:  r_lp      <= i_cfg_data[15:0];
                bpr_pkg::CFG_LAMBDA_NEG:  r_ln      <= i_cfg_data[15:0];
                bpr_pkg::CFG_FACTORS:     r_factors <= i_cfg_data[6:0];
                bpr_pkg::CFG_USERS:       r_users   <= i_cfg_data[10:0];
                bpr_pkg::CFG_ITEMS:       r_items   <= i_cfg_data[12:0];
                bpr_pkg::CFG_GLOBAL_MEAN: r_gmean   <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
        end
    end

    // Command checks.
    always_comb begin
        is_load = (r_cmd.mode == bpr_pkg::MODE_LOAD_USER) ||
                  (r_cmd.mode == bpr_pkg::MODE_LOAD_ITEM);
        if (r_cmd.mode == bpr_pkg::MODE_LOAD_USER) begin
            load_err = 32'(r_cmd.user_index) >= 32'(bpr_pkg::MAX_USERS);
        end else begin
            load_err = 32'(r_cmd.pos_item_index) >= 32'(bpr_pkg::MAX_ITEMS);
        end
        load_err = load_err || (32'(r_cmd.factor_index) >= 32'(bpr_pkg::MAX_FACTORS));
        u_bad = (32'(r_cmd.user_index) >= 32'(r_users)) ||
                (32'(r_cmd.user_index) >= 32'(bpr_pkg::MAX_USERS));
        i_bad = (32'(r_cmd.pos_item_index) >= 32'(r_items)) ||
                (32'(r_cmd.pos_item_index) >= 32'(bpr_pkg::MAX_ITEMS));
        j_bad = (32'(r_cmd.neg_item_index) >= 32'(r_items)) ||
                (32'(r_cmd.neg_item_index) >= 32'(bpr_pkg::MAX_ITEMS));
        o_sts.mode     = r_cmd.mode;
        o_sts.load_err = load_err;
        o_sts.rng_err  = u_bad || i_bad ||
                         ((r_cmd.mode == bpr_pkg::MODE_TRAIN) && j_bad);
        o_sts.nf       = (32'(r_factors) > 32'(bpr_pkg::MAX_FACTORS)) ?
                         bpr_pkg::FCNT_W'(bpr_pkg::MAX_FACTORS) :
                         bpr_pkg::FCNT_W'(r_factors);
        o_sts.dot_busy = r_v1 || r_v2 || r_v3;
    end

    // Update arithmetic.
    always_comb begin
        gu     = bpr_pkg::sat32(66'(r_m[0]) - 66'(r_m[1]));
        gi     = bpr_pkg::sat32(66'(r_m[2]) - 66'(r_m[3]));
        gj     = bpr_pkg::sat32(66'(r_m[4]) - 66'(r_m[5]));
        new_w  = bpr_pkg::sat32(66'(r_w) + 66'(r_m[6]));
        new_hi = bpr_pkg::sat32(66'(r_hi) + 66'(r_m[7]));
        j_base = (r_cmd.pos_item_index == r_cmd.neg_item_index) ? r_newi : r_hj;
        new_j  = bpr_pkg::sat32(66'(j_base) + 66'(r_m[8]));
        x_sat  = bpr_pkg::sat32(66'(r_acc));
    end

    // Store addressing.
    always_comb begin
        u_addr = {r_cmd.user_index[bpr_pkg::USER_IW-1:0], i_ctl.f};
        i_addr = {r_cmd.pos_item_index[bpr_pkg::ITEM_IW-1:0], i_ctl.f};
        j_addr = {r_cmd.neg_item_index[bpr_pkg::ITEM_IW-1:0], i_ctl.f};
        u_we = (i_ctl.load && !load_err && (r_cmd.mode == bpr_pkg::MODE_LOAD_USER)) ||
               i_ctl.wr_i;
        it_we = (i_ctl.load && !load_err && (r_cmd.mode == bpr_pkg::MODE_LOAD_ITEM)) ||
                i_ctl.wr_i || i_ctl.wr_j;
        if (i_ctl.load) begin
            u_wr_addr  = {r_cmd.user_index[bpr_pkg::USER_IW-1:0],
                          r_cmd.factor_index[bpr_pkg::FIDX_W-1:0]};
            it_wr_addr = {r_cmd.pos_item_index[bpr_pkg::ITEM_IW-1:0],
                          r_cmd.factor_index[bpr_pkg::FIDX_W-1:0]};
            u_wr_data  = r_cmd.factor_value;
            it_wr_data = r_cmd.factor_value;
        end else begin
            u_wr_addr  = u_addr;
            it_wr_addr = i_ctl.wr_j ? j_addr : i_addr;
            u_wr_data  = new_w;
            it_wr_data = i_ctl.wr_j ? new_j : new_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            user_mem[u_wr_addr] <= u_wr_data;
        end
        if (i_ctl.rd) begin
            r_w <= user_mem[u_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (it_we) begin
            item_mem[it_wr_addr] <= it_wr_data;
        end
        if (i_ctl.rd) begin
            r_hi <= item_mem[i_addr];
            r_hj <= item_mem[j_addr];
        end
    end

    // Shared multiplier operands.
    always_comb begin
        mul_a = 33'(r_wq);
        mul_b = 33'(r_diff);
        if (i_ctl.op_en) begin
            unique case (i_ctl.op_step)
                bpr_pkg::OP_D_DIFF: begin
                    mul_a = 33'(r_d);
                    mul_b = 33'(r_diff);
                end
                bpr_pkg::OP_LU_W: begin
                    mul_a = 33'(r_lu);
                    mul_b = 33'(r_w);
                end
                bpr_pkg::OP_D_W: begin
                    mul_a = 33'(r_d);
                    mul_b = 33'(r_w);
                end
                bpr_pkg::OP_LP_HI: begin
                    mul_a = 33'(r_lp);
                    mul_b = 33'(r_hi);
                end
                bpr_pkg::OP_D_NEGW: begin
                    mul_a = 33'(r_d);
                    mul_b = -(33'(r_w));
                end
                bpr_pkg::OP_LN_HJ: begin
                    mul_a = 33'(r_ln);
                    mul_b = 33'(r_hj);
                end
                bpr_pkg::OP_LR_GU: begin
                    mul_a = 33'(r_lr);
                    mul_b = 33'(gu);
                end
                bpr_pkg::OP_LR_GI: begin
                    mul_a = 33'(r_lr);
                    mul_b = 33'(gi);
                end
                bpr_pkg::OP_LR_GJ: begin
                    mul_a = 33'(r_lr);
                    mul_b = 33'(gj);
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // Logistic weight from the clamped, interpolated table.
    always_comb begin
        x_abs  = r_x[31] ? 33'(-(33'(r_x))) : 33'(r_x);
        a_cl   = (x_abs > 33'd134217728) ? 28'd134217728 : x_abs[27:0];
        s_idx  = a_cl[27:23];
        s_frac = a_cl[22:0];
        t0     = bpr_pkg::sig_tab(s_idx);
        t1     = bpr_pkg::sig_tab(s_idx + 5'd1);
        drop   = t0 - t1;
        interp = 38'(drop) * 38'(s_frac) + 38'h40_0000;
        d_pos  = (s_idx >= 5'd16) ? 17'(bpr_pkg::sig_tab(5'd16)) :
                 17'(t0) - 17'(interp[37:23]);
        d_fin  = r_x[31] ? (17'd65536 - d_pos) : d_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.rd && i_ctl.dot;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wq   <= r_w;
        r_diff <= (r_cmd.mode == bpr_pkg::MODE_PREDICT) ? r_hi :
                  bpr_pkg::sat32(66'(r_hi) - 66'(r_hj));
        r_prod <= 66'(mul_a) * 66'(mul_b);
        if (i_ctl.capture) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc +
                     bpr_pkg::ACC_W'(bpr_pkg::sat32(bpr_pkg::rnd_shr(r_prod, 24)));
        end
        if (i_ctl.op_en && (i_ctl.op_step != bpr_pkg::OP_D_DIFF)) begin
            r_m[i_ctl.op_step - 4'd1] <= bpr_pkg::sat32(bpr_pkg::rnd_shr(r_prod, 16));
        end
        if (i_ctl.xsat) begin
            r_x <= x_sat;
        end
        if (i_ctl.sig) begin
            r_d <= d_fin[15:0];
        end
        if (i_ctl.wr_i) begin
            r_newi <= new_hi;
        end
        if (i_ctl.load) begin
            r_res.result_value <= '0;
            r_res.status       <= load_err;
        end else if (i_ctl.res_err) begin
            r_res.result_value <= r_gmean;
            r_res.status       <= 1'b1;
        end else if (i_ctl.xsat) begin
            r_res.result_value <= x_sat;
            r_res.status       <= 1'b0;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

@@ rtl/core/bpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// BPR SGD step controller
// Sequences the command check, the dot pass, the logistic weight and the per-factor update.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bpr_matrix_factor_sgd_step_top_defines.svh"

module bpr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire bpr_pkg::t_dp_sts i_sts,
    output logic                  o_busy,
    output logic                  o_done,
    output bpr_pkg::t_dp_ctl      o_ctl
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_DOT, ST_XSAT, ST_SIG,
        ST_URD, ST_UWAIT, ST_UOP, ST_UWI, ST_UWJ
    } t_state;

    t_state                     r_state;
    logic [bpr_pkg::FCNT_W-1:0] r_f;
    logic [bpr_pkg::STEP_W-1:0] r_step;
    logic                       r_busy, r_done;
    bpr_pkg::t_dp_ctl           ctl;

    always_comb begin
        ctl         = '0;
        ctl.f       = r_f[bpr_pkg::FIDX_W-1:0];
        ctl.op_step = r_step;
        unique case (r_state)
            ST_IDLE:  ctl.capture = i_start;
            ST_CHECK: begin
                if ((i_sts.mode == bpr_pkg::MODE_LOAD_USER) ||
                    (i_sts.mode == bpr_pkg::MODE_LOAD_ITEM)) begin
                    ctl.load = 1'b1;
                end else if (i_sts.rng_err) begin
                    ctl.res_err = 1'b1;
                end
            end
            ST_DOT: begin
                ctl.rd  = r_f < i_sts.nf;
                ctl.dot = r_f < i_sts.nf;
            end
            ST_XSAT:  ctl.xsat  = 1'b1;
            ST_SIG:   ctl.sig   = 1'b1;
            ST_URD:   ctl.rd    = 1'b1;
            ST_UWAIT: ;
            ST_UOP:   ctl.op_en = 1'b1;
            ST_UWI:   ctl.wr_i  = 1'b1;
            ST_UWJ:   ctl.wr_j  = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_f     <= '0;
            r_step  <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_busy  <= 1'b1;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (ctl.load || ctl.res_err) begin
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_f     <= '0;
                        r_state <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    if (ctl.rd) begin
                        r_f <= r_f + bpr_pkg::FCNT_W'(1);
                    end else if (!i_sts.dot_busy) begin
                        r_state <= ST_XSAT;
                    end
                end
                ST_XSAT: begin
                    if (i_sts.mode == bpr_pkg::MODE_PREDICT) begin
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_SIG;
                    end
                end
                ST_SIG: begin
                    r_f <= '0;
                    if (i_sts.nf == '0) begin
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_URD;
                    end
                end
                ST_URD:   r_state <= ST_UWAIT;
                ST_UWAIT: begin
                    r_step  <= bpr_pkg::OP_D_DIFF;
                    r_state <= ST_UOP;
                end
                ST_UOP: begin
                    if (r_step == bpr_pkg::OP_RETIRE) begin
                        r_state <= ST_UWI;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_UWI:   r_state <= ST_UWJ;
                ST_UWJ: begin
                    if ((r_f + bpr_pkg::FCNT_W'(1)) < i_sts.nf) begin
                        r_f     <= r_f + bpr_pkg::FCNT_W'(1);
                        r_state <= ST_URD;
                    end else begin
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_ctl  = ctl;

    `BPR_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy && (r_state == ST_IDLE), "Result word shown while busy.")
    `BPR_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !r_busy, r_busy && !r_done, "Accepted word did not raise busy.")
    `BPR_ASSERT_IMP(a_wrj_after_wri, i_clk, i_rst_n, ctl.wr_j, $past(ctl.wr_i), "Other item written without liked item first.")

endmodule

`default_nettype wire

@@ rtl/core/bpr_matrix_factor_sgd_step_top.sv @@
// Loads and out-of-range requests end in the check state and give their result word there.
// Predict runs the dot pass over the nf factors in use; a train step adds the update pass.
// The update pass sets the train rate: one shared multiplier runs nine products per factor.
// One word at a time; busy stays high until the result strobe; the receiver cannot stall.
// Reset restores the configuration defaults and idles the sequencer; stores keep contents.
// ----------------------------------------------------------------------------
// BPR matrix factorization SGD step engine
// Top level joining the step controller and the factor datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_matrix_factor_sgd_step_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bpr_pkg::t_cmd    i_cmd,
    output logic                  o_done,
    output bpr_pkg::t_result      o_result,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data
);

    bpr_pkg::t_dp_ctl dp_ctl;
    bpr_pkg::t_dp_sts dp_sts;

    bpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctl   (dp_ctl)
    );

    bpr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (dp_ctl),
        .o_sts      (dp_sts),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
